@@ rtl/pointer_input_tracker_macros.svh @@
// assertion macros shared by the pointer input tracker checker
// no dependencies; included by files that hold concurrent assertions
`ifndef POINTER_INPUT_TRACKER_MACROS_SVH
`define POINTER_INPUT_TRACKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PIT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pointer tracker check failed");

// next-cycle implication, disabled during reset
`define PIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pointer tracker check failed");

`endif

@@ rtl/pit_pkg.sv @@
// types and constants for the pointer input tracker
// no dependencies; used by every other rtl .sv file
`default_nettype none

package pit_pkg;

   localparam int DELTA_W  = 16;
   localparam int BUTTON_W = 3;
   localparam int KEY_W    = 8;
   localparam int TIME_W   = 32;
   localparam int PTR_W    = 12;
   localparam int SIZE_W   = 13;
   localparam int WINDOW_W = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // largest value a size register can hold
   localparam int SIZE_REG_MAX = 8191;

   localparam logic [SIZE_W-1:0]   RESET_WIDTH  = 13'd1024;
   localparam logic [SIZE_W-1:0]   RESET_HEIGHT = 13'd768;
   localparam logic [WINDOW_W-1:0] RESET_WINDOW = 16'd500;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] REG_CLICK_WINDOW  = 2'd2;

   // button bit positions
   localparam int BTN_LEFT  = 0;
   localparam int BTN_RIGHT = 1;

   typedef struct packed {
      logic [SIZE_W-1:0]   screen_width;
      logic [SIZE_W-1:0]   screen_height;
      logic [WINDOW_W-1:0] double_click_window;
   } cfg_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0] delta_x;
      logic signed [DELTA_W-1:0] delta_y;
      logic [BUTTON_W-1:0]       button_bits;
      logic                      key_present;
      logic [KEY_W-1:0]          key_code;
      logic [TIME_W-1:0]         time_now;
   } req_item_type;

   typedef struct packed {
      logic left_press;
      logic left_release;
      logic right_press;
      logic double_click;
      logic activity;
   } event_type;

   typedef struct packed {
      logic [PTR_W-1:0] pointer_x;
      logic [PTR_W-1:0] pointer_y;
      event_type        events;
      logic             key_valid;
      logic [KEY_W-1:0] key_out;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ rtl/pit_if.sv @@
// valid/ready channel interfaces for poll beats and result beats
// depends on pit_pkg for field widths
`default_nettype none

interface pit_req_if;
   import pit_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [DELTA_W-1:0] delta_x;
   logic signed [DELTA_W-1:0] delta_y;
   logic [BUTTON_W-1:0]       button_bits;
   logic                      key_present;
   logic [KEY_W-1:0]          key_code;
   logic [TIME_W-1:0]         time_now;

   modport source (output valid, delta_x, delta_y, button_bits, key_present, key_code,
                   time_now, input ready);
   modport sink (input valid, delta_x, delta_y, button_bits, key_present, key_code,
                 time_now, output ready);
endinterface

interface pit_rsp_if;
   import pit_pkg::*;

   logic             valid;
   logic             ready;
   logic [PTR_W-1:0] pointer_x;
   logic [PTR_W-1:0] pointer_y;
   logic             left_press;
   logic             left_release;
   logic             right_press;
   logic             double_click;
   logic             activity;
   logic             key_valid;
   logic [KEY_W-1:0] key_out;

   modport source (output valid, pointer_x, pointer_y, left_press, left_release,
                   right_press, double_click, activity, key_valid, key_out, input ready);
   modport sink (input valid, pointer_x, pointer_y, left_press, left_release,
                 right_press, double_click, activity, key_valid, key_out, output ready);
endinterface

`default_nettype wire

@@ rtl/pit_csr.sv @@
// apb-style configuration registers: screen size and double click window
// depends on pit_pkg
`default_nettype none

module pit_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [pit_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [pit_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [pit_pkg::CSR_DATA_W-1:0] prdata,
   output logic                               pready,
   output pit_pkg::cfg_type                   cfg
);
   import pit_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SCREEN_WIDTH:  cfg_in.screen_width        = pwdata[SIZE_W-1:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_height       = pwdata[SIZE_W-1:0];
            REG_CLICK_WINDOW:  cfg_in.double_click_window = pwdata[WINDOW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SCREEN_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.screen_width);
         REG_SCREEN_HEIGHT: prdata = CSR_DATA_W'(cfg_ff.screen_height);
         REG_CLICK_WINDOW:  prdata = CSR_DATA_W'(cfg_ff.double_click_window);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width        <= RESET_WIDTH;
         cfg_ff.screen_height       <= RESET_HEIGHT;
         cfg_ff.double_click_window <= RESET_WINDOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/pit_axis.sv @@
// one pointer axis: add signed delta, clamp to 0 .. limit-1
// depends on pit_pkg
`default_nettype none

module pit_axis #(
   parameter int SCREEN_MAX = 4096,
   parameter int POS_W      = 12
) (
   input  wire logic        [POS_W-1:0]              pos,
   input  wire logic signed [pit_pkg::DELTA_W-1:0]   delta,
   input  wire logic        [pit_pkg::SIZE_W-1:0]    size,
   output logic             [POS_W-1:0]              pos_next
);
   import pit_pkg::*;

   localparam int SUM_W = ((POS_W > 17) ? POS_W : 17) + 2;

   logic signed [SUM_W-1:0] pos_s;
   logic signed [SUM_W-1:0] delta_s;
   logic signed [SUM_W-1:0] size_s;
   logic signed [SUM_W-1:0] lim_s;
   logic signed [SUM_W-1:0] sum_s;
   logic signed [SUM_W-1:0] clamp_s;

   assign pos_s   = $signed({{(SUM_W-POS_W){1'b0}}, pos});
   assign delta_s = $signed({{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta});
   assign size_s  = $signed({{(SUM_W-SIZE_W){1'b0}}, size});
   assign sum_s   = pos_s + delta_s;

   // zero size pins the axis, oversized saturates at the build limit
   always_comb begin
      priority if (size == '0) lim_s = SUM_W'(1);
      else if (size_s > SUM_W'(SCREEN_MAX)) lim_s = SUM_W'(SCREEN_MAX);
      else lim_s = size_s;
   end

   always_comb begin
      clamp_s = sum_s;
      if (clamp_s < 0) clamp_s = '0;
      if (clamp_s >= lim_s) clamp_s = lim_s - SUM_W'(1);
   end

   assign pos_next = clamp_s[POS_W-1:0];

endmodule

`default_nettype wire

@@ rtl/pit_event.sv @@
// button edge, double click and activity decode for one poll
// depends on pit_pkg
`default_nettype none

module pit_event (
   input  wire pit_pkg::req_item_type                item,
   input  wire logic [pit_pkg::BUTTON_W-1:0]         last_buttons,
   input  wire logic [pit_pkg::TIME_W-1:0]           last_click_time,
   input  wire logic [pit_pkg::WINDOW_W-1:0]         window,
   output pit_pkg::event_type                        events
);
   import pit_pkg::*;

   logic [TIME_W-1:0] elapsed;
   logic              left_now;
   logic              left_prev;
   logic              right_now;
   logic              right_prev;

   assign left_now   = item.button_bits[BTN_LEFT];
   assign left_prev  = last_buttons[BTN_LEFT];
   assign right_now  = item.button_bits[BTN_RIGHT];
   assign right_prev = last_buttons[BTN_RIGHT];

   // wrapping difference since the previous left press
   assign elapsed = item.time_now - last_click_time;

   always_comb begin
      events.left_press   = left_now & ~left_prev;
      events.left_release = ~left_now & left_prev;
      events.right_press  = right_now & ~right_prev;
      events.double_click = events.left_press &
                            (elapsed < {{(TIME_W-WINDOW_W){1'b0}}, window});
      events.activity     = (item.delta_x != '0) | (item.delta_y != '0) |
                            (item.button_bits != last_buttons) | item.key_present;
   end

endmodule

`default_nettype wire

@@ rtl/pointer_input_tracker.sv @@
// pointer input tracker top level: poll register, update logic, result register
// depends on pit_pkg, pit_if, pit_csr, pit_axis, pit_event
//
//  channel | dir | handshake          | beat contents
//  --------+-----+--------------------+----------------------------------------------
//  req     | in  | valid/ready        | deltas, buttons, key, timestamp
//  rsp     | out | valid/ready        | clamped pointer, edges, click, activity, key
//  csr     | in  | psel/penable/pready| screen width, screen height, click window
//
//  one poll beat per cycle sustained while rsp is not stalled; a poll is held in the input
//  register, then moves on into the result register that drives rsp
//  the pointer/button/click state updates at the same edge the result is loaded,
//  which keeps back-to-back polls in order with no bubble
//  a stalled rsp holds the result register; the input register still fills, and req
//  ready drops only when both registers are full and rsp is stalled
//  synchronous active-high reset restores the register defaults and centers the pointer
`default_nettype none

module pointer_input_tracker #(
   parameter int SCREEN_MAX = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   pit_req_if.sink                            req,
   pit_rsp_if.source                          rsp,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [pit_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [pit_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [pit_pkg::CSR_DATA_W-1:0] prdata,
   output logic                               pready
);
   import pit_pkg::*;

   // position never reaches the size register ceiling or the build limit
   localparam int LIM_MAX  = (SCREEN_MAX < SIZE_REG_MAX) ? SCREEN_MAX : SIZE_REG_MAX;
   localparam int LIM_BITS = $clog2(LIM_MAX);
   // wide enough for the reset center too
   localparam int POS_W    = (LIM_BITS > 10) ? LIM_BITS : 10;

   cfg_type cfg;

   // input register
   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_item_type s1_item_ff;
   req_item_type req_item;

   // result register
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;

   // tracker state
   logic [POS_W-1:0]    pos_x_ff;
   logic [POS_W-1:0]    pos_x_in;
   logic [POS_W-1:0]    pos_y_ff;
   logic [POS_W-1:0]    pos_y_in;
   logic [BUTTON_W-1:0] last_buttons_ff;
   logic [TIME_W-1:0]   last_click_ff;
   logic [TIME_W-1:0]   last_click_in;

   event_type events;
   logic      advance;
   logic      req_take;

   pit_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // handshake: the held poll moves on when the result slot is free or draining
   assign advance   = s1_valid_ff & (~rsp_valid_ff | rsp.ready);
   assign req.ready = ~s1_valid_ff | advance;
   assign req_take  = req.valid & req.ready;

   assign req_item.delta_x     = req.delta_x;
   assign req_item.delta_y     = req.delta_y;
   assign req_item.button_bits = req.button_bits;
   assign req_item.key_present = req.key_present;
   assign req_item.key_code    = req.key_code;
   assign req_item.time_now    = req.time_now;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (advance) s1_valid_in = 1'b0;
      if (req_take) s1_valid_in = 1'b1;
   end

   // update logic between the registers
   pit_axis #(.SCREEN_MAX(SCREEN_MAX), .POS_W(POS_W)) u_axis_x (
      .pos      (pos_x_ff),
      .delta    (s1_item_ff.delta_x),
      .size     (cfg.screen_width),
      .pos_next (pos_x_in)
   );

   pit_axis #(.SCREEN_MAX(SCREEN_MAX), .POS_W(POS_W)) u_axis_y (
      .pos      (pos_y_ff),
      .delta    (s1_item_ff.delta_y),
      .size     (cfg.screen_height),
      .pos_next (pos_y_in)
   );

   pit_event u_event (
      .item            (s1_item_ff),
      .last_buttons    (last_buttons_ff),
      .last_click_time (last_click_ff),
      .window          (cfg.double_click_window),
      .events          (events)
   );

   // only a left press stamps the click time
   assign last_click_in = events.left_press ? s1_item_ff.time_now : last_click_ff;

   always_comb begin
      rsp_item_in.pointer_x = PTR_W'(pos_x_in);
      rsp_item_in.pointer_y = PTR_W'(pos_y_in);
      rsp_item_in.events    = events;
      rsp_item_in.key_valid = s1_item_ff.key_present;
      rsp_item_in.key_out   = s1_item_ff.key_present ? s1_item_ff.key_code : '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp.ready) rsp_valid_in = 1'b0;
      if (advance) rsp_valid_in = 1'b1;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         pos_x_ff        <= POS_W'(RESET_WIDTH / 2);
         pos_y_ff        <= POS_W'(RESET_HEIGHT / 2);
         last_buttons_ff <= '0;
         last_click_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            pos_x_ff        <= pos_x_in;
            pos_y_ff        <= pos_y_in;
            last_buttons_ff <= s1_item_ff.button_bits;
            last_click_ff   <= last_click_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) s1_item_ff <= req_item;
      if (advance) rsp_item_ff <= rsp_item_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pointer_x    = rsp_item_ff.pointer_x;
   assign rsp.pointer_y    = rsp_item_ff.pointer_y;
   assign rsp.left_press   = rsp_item_ff.events.left_press;
   assign rsp.left_release = rsp_item_ff.events.left_release;
   assign rsp.right_press  = rsp_item_ff.events.right_press;
   assign rsp.double_click = rsp_item_ff.events.double_click;
   assign rsp.activity     = rsp_item_ff.events.activity;
   assign rsp.key_valid    = rsp_item_ff.key_valid;
   assign rsp.key_out      = rsp_item_ff.key_out;

endmodule

`default_nettype wire

@@ rtl/pit_checker.sv @@
// port-level checks on result beats of the pointer input tracker, plus bind
// depends on pit_pkg and pointer_input_tracker_macros.svh
`default_nettype none

`include "pointer_input_tracker_macros.svh"

module pit_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [pit_pkg::PTR_W-1:0]  pointer_x,
   input wire logic                       left_press,
   input wire logic                       left_release,
   input wire logic                       right_press,
   input wire logic                       double_click,
   input wire logic                       activity,
   input wire logic                       key_valid,
   input wire logic [pit_pkg::KEY_W-1:0]  key_out
);
   import pit_pkg::*;

   // a stalled result beat stays valid with pointer_x and key_out stable
   `PIT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(pointer_x) && $stable(key_out))

   // double click only on a left press
   `PIT_ASSERT_NOW(a_dbl_needs_press, clock, reset, rsp_valid && double_click, left_press)

   // any edge or key implies activity; press and release never together
   `PIT_ASSERT_NOW(a_edges_active, clock, reset, rsp_valid && (left_press || left_release || right_press || key_valid), activity && !(left_press && left_release))

   // no key means a zero code
   `PIT_ASSERT_NOW(a_key_zero, clock, reset, rsp_valid && !key_valid, key_out == '0)

endmodule

bind pointer_input_tracker pit_checker u_pit_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .pointer_x    (rsp.pointer_x),
   .left_press   (rsp.left_press),
   .left_release (rsp.left_release),
   .right_press  (rsp.right_press),
   .double_click (rsp.double_click),
   .activity     (rsp.activity),
   .key_valid    (rsp.key_valid),
   .key_out      (rsp.key_out)
);

`default_nettype wire

@@ test/pointer_input_tracker_tb.sv @@
// testbench for the pointer input tracker: poll beats in, pointer/click reports out
// depends on pit_pkg, pit_if and pointer_input_tracker from the rtl folder
`default_nettype none

module pointer_input_tracker_tb;
   import pit_pkg::*;

   localparam int SCREEN_MAX  = 4096;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_POLLS = 80;

   // predicts pointer position, button edges, double clicks, activity and key for each accepted poll
   class pointer_scoreboard;
      logic [SIZE_W-1:0]   width;
      logic [SIZE_W-1:0]   height;
      logic [WINDOW_W-1:0] window;
      logic [PTR_W-1:0]    pos_x;
      logic [PTR_W-1:0]    pos_y;
      logic [BUTTON_W-1:0] held;
      logic [TIME_W-1:0]   last_press;
      rsp_item_type        due_reports[$];
      int                  errors;

      function new();
         width      = RESET_WIDTH;
         height     = RESET_HEIGHT;
         window     = RESET_WINDOW;
         pos_x      = PTR_W'(RESET_WIDTH / 2);
         pos_y      = PTR_W'(RESET_HEIGHT / 2);
         held       = '0;
         last_press = '0;
         errors     = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_SCREEN_WIDTH: begin
               width = value[SIZE_W-1:0];
            end
            REG_SCREEN_HEIGHT: begin
               height = value[SIZE_W-1:0];
            end
            REG_CLICK_WINDOW: begin
               window = value[WINDOW_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // size 0 behaves as 1, sizes past the screen limit behave as the limit
      function logic [PTR_W-1:0] step_axis(logic [PTR_W-1:0] pos,
                                           logic signed [DELTA_W-1:0] delta,
                                           logic [SIZE_W-1:0] size);
         int lim;
         int spot;
         lim  = (size == 0) ? 1 : ((size > SCREEN_MAX) ? SCREEN_MAX : int'(size));
         spot = int'(pos) + int'(delta);
         if (spot < 0) spot = 0;
         if (spot >= lim) spot = lim - 1;
         return spot[PTR_W-1:0];
      endfunction

      function void note_poll(req_item_type p);
         rsp_item_type        r;
         logic [BUTTON_W-1:0] prev;
         prev  = held;
         r     = '0;
         pos_x = step_axis(pos_x, p.delta_x, width);
         pos_y = step_axis(pos_y, p.delta_y, height);
         r.pointer_x = pos_x;
         r.pointer_y = pos_y;
         if (p.button_bits[BTN_LEFT] && !prev[BTN_LEFT]) begin
            r.events.left_press   = 1'b1;
            r.events.double_click = (p.time_now - last_press) < {16'd0, window};
            last_press            = p.time_now;
         end
         r.events.left_release = !p.button_bits[BTN_LEFT] && prev[BTN_LEFT];
         r.events.right_press  = p.button_bits[BTN_RIGHT] && !prev[BTN_RIGHT];
         r.events.activity     = (p.delta_x != 0) || (p.delta_y != 0) ||
                                 (p.button_bits != prev) || p.key_present;
         held        = p.button_bits;
         r.key_valid = p.key_present;
         r.key_out   = p.key_present ? p.key_code : '0;
         due_reports.push_back(r);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_report(rsp_item_type got);
         rsp_item_type want;
         if (due_reports.size() == 0) begin
            $error("result beat with no poll waiting for it");
            errors++;
            return;
         end
         want = due_reports.pop_front();
         compare_field("pointer_x", 32'(want.pointer_x), 32'(got.pointer_x));
         compare_field("pointer_y", 32'(want.pointer_y), 32'(got.pointer_y));
         compare_field("left_press", 32'(want.events.left_press),
                       32'(got.events.left_press));
         compare_field("left_release", 32'(want.events.left_release),
                       32'(got.events.left_release));
         compare_field("right_press", 32'(want.events.right_press),
                       32'(got.events.right_press));
         compare_field("double_click", 32'(want.events.double_click),
                       32'(got.events.double_click));
         compare_field("activity", 32'(want.events.activity), 32'(got.events.activity));
         compare_field("key_valid", 32'(want.key_valid), 32'(got.key_valid));
         compare_field("key_out", 32'(want.key_out), 32'(got.key_out));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   pit_req_if req_bus ();
   pit_rsp_if rsp_bus ();

   pointer_scoreboard   tracker;
   bit                  steady;        // sender offers beats back to back when set
   logic [TIME_W-1:0]   tick_ms;       // running timestamp for well-formed polls
   logic [BUTTON_W-1:0] hand_buttons;  // buttons the simulated user is holding

   pointer_input_tracker #(
      .SCREEN_MAX(SCREEN_MAX)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .rsp    (rsp_bus),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // apb write: setup cycle, then access cycle until pready
   // called right after a rising edge, returns right after the write edge
   task automatic write_reg(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      tracker.set_reg(idx, value);
   endtask

   task automatic write_screen(input logic [CSR_DATA_W-1:0] w,
                               input logic [CSR_DATA_W-1:0] h,
                               input logic [CSR_DATA_W-1:0] win);
      write_reg(REG_SCREEN_WIDTH, w);
      write_reg(REG_SCREEN_HEIGHT, h);
      write_reg(REG_CLICK_WINDOW, win);
   endtask

   // offer one poll beat and return right after the edge that accepts it
   // valid stays high on return so the next beat can follow with no bubble
   task automatic send_poll(input req_item_type p);
      int gap;
      gap = 0;
      if (!steady) begin
         while ($urandom_range(99) < 34) gap++;
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.delta_x     <= p.delta_x;
      req_bus.delta_y     <= p.delta_y;
      req_bus.button_bits <= p.button_bits;
      req_bus.key_present <= p.key_present;
      req_bus.key_code    <= p.key_code;
      req_bus.time_now    <= p.time_now;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      tracker.note_poll(p);
   endtask

   function automatic req_item_type make_poll(int dx, int dy, int buttons, bit key_p,
                                              int key_c, logic [TIME_W-1:0] stamp);
      req_item_type p;
      p.delta_x     = DELTA_W'(dx);
      p.delta_y     = DELTA_W'(dy);
      p.button_bits = BUTTON_W'(buttons);
      p.key_present = key_p;
      p.key_code    = KEY_W'(key_c);
      p.time_now    = stamp;
      return p;
   endfunction

   // mostly a plausible user: small moves, buttons held for a while, time moving
   // forward; now and then a poll with wild deltas or a random timestamp
   function automatic req_item_type random_poll();
      req_item_type p;
      int           pick;
      pick = $urandom_range(99);
      if (pick < 20) begin
         p.delta_x = '0;
         p.delta_y = '0;
      end else if (pick < 90) begin
         p.delta_x = DELTA_W'(int'($urandom_range(80)) - 40);
         p.delta_y = DELTA_W'(int'($urandom_range(80)) - 40);
      end else begin
         p.delta_x = DELTA_W'($urandom);
         p.delta_y = DELTA_W'($urandom);
      end
      if ($urandom_range(99) >= 60) hand_buttons = BUTTON_W'($urandom_range(7));
      p.button_bits = hand_buttons;
      p.key_present = ($urandom_range(99) < 30);
      p.key_code    = KEY_W'($urandom_range(255));
      if ($urandom_range(99) < 5) tick_ms = $urandom;
      else tick_ms = tick_ms + $urandom_range(300);
      p.time_now = tick_ms;
      return p;
   endfunction

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++) send_poll(random_poll());
      req_bus.valid <= 1'b0;
   endtask

   // wait for every report to come back, then let the pipe settle
   task automatic wait_drained();
      while (tracker.due_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // result side: check each beat, throttle ready, one long hold-off to back up the pipe
   initial begin
      rsp_item_type got;
      int           hold_left;
      int           seen;
      bit           hold_done;
      rsp_bus.ready <= 1'b0;
      hold_left = 0;
      seen      = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.pointer_x           = rsp_bus.pointer_x;
            got.pointer_y           = rsp_bus.pointer_y;
            got.events.left_press   = rsp_bus.left_press;
            got.events.left_release = rsp_bus.left_release;
            got.events.right_press  = rsp_bus.right_press;
            got.events.double_click = rsp_bus.double_click;
            got.events.activity     = rsp_bus.activity;
            got.key_valid           = rsp_bus.key_valid;
            got.key_out             = rsp_bus.key_out;
            tracker.check_report(got);
            seen++;
         end
         if (hold_left > 0) begin
            hold_left--;
         end else if (!hold_done && seen >= 60) begin
            // long stall in the middle of a random run: input must back up
            hold_left = 80;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (seen >= 200 && seen < 280) begin
            // stretch with ready held high
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= 34);
         end
      end
   end

   // cycle limit
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      tracker = new();
      steady  = 1'b0;
      tick_ms = '0;
      hand_buttons = '0;
      reset   <= 1'b1;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.delta_x     <= '0;
      req_bus.delta_y     <= '0;
      req_bus.button_bits <= '0;
      req_bus.key_present <= 1'b0;
      req_bus.key_code    <= '0;
      req_bus.time_now    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed polls on the reset settings (1024 x 768, window 500)
      send_poll(make_poll(0, 0, 0, 1'b0, 0, 0));                // nothing happened
      send_poll(make_poll(32767, 32767, 0, 1'b0, 0, 5));        // pinned at bottom right
      send_poll(make_poll(-32768, -32768, 0, 1'b0, 0, 10));     // pinned at top left
      send_poll(make_poll(5, -1, 0, 1'b0, 0, 20));              // y stays clamped at 0
      send_poll(make_poll(0, 0, 1, 1'b0, 0, 100));              // first press near zero: double
      send_poll(make_poll(0, 0, 0, 1'b0, 0, 150));              // left release
      send_poll(make_poll(0, 0, 1, 1'b0, 0, 400));              // second press inside window
      send_poll(make_poll(0, 0, 3, 1'b0, 0, 450));              // right press
      send_poll(make_poll(0, 0, 7, 1'b0, 0, 460));              // middle alone: activity only
      send_poll(make_poll(0, 0, 7, 1'b1, 255, 470));            // key with top code
      send_poll(make_poll(0, 0, 7, 1'b0, 8'hA5, 480));          // stale code, no key
      send_poll(make_poll(0, 0, 0, 1'b0, 0, 1000));             // left release, right dropped
      send_poll(make_poll(0, 0, 1, 1'b0, 0, 900));              // exactly at window: no double
      send_poll(make_poll(0, 0, 0, 1'b0, 0, 1000));
      send_poll(make_poll(0, 0, 1, 1'b0, 0, 1399));             // one tick inside window
      send_poll(make_poll(0, 0, 0, 1'b0, 0, 32'hFFFF_FF00));
      send_poll(make_poll(0, 0, 1, 1'b0, 0, 32'hFFFF_FFF0));    // far apart: no double
      send_poll(make_poll(0, 0, 0, 1'b0, 0, 32'h0000_0010));
      send_poll(make_poll(0, 0, 1, 1'b0, 0, 32'h0000_0020));    // across wrap: double
      send_poll(make_poll(0, 0, 1, 1'b1, 0, 32'h0000_0030));    // key code zero
      send_poll(make_poll(1, 1, 1, 1'b0, 0, 32'h0000_0040));
      req_bus.valid <= 1'b0;
      wait_drained();

      // smallest screen, window off
      write_screen(32'd1, 32'd1, 32'd0);
      run_random(PHASE_POLLS);
      wait_drained();

      // largest legal screen and window
      write_screen(32'd4096, 32'd4096, 32'd65535);
      run_random(PHASE_POLLS);
      wait_drained();

      // zero width and oversized height, junk in the upper data bits
      write_screen(32'hFFFF_E000, 32'hFFFF_FFFF, 32'hABCD_0000 | $urandom_range(2000));
      run_random(PHASE_POLLS);
      wait_drained();

      // small screens so clamping is frequent, beats back to back
      steady = 1'b1;
      write_screen($urandom_range(300, 16), $urandom_range(300, 16), $urandom_range(2000, 1));
      run_random(PHASE_POLLS);
      wait_drained();
      steady = 1'b0;

      // anything the registers can hold
      write_screen($urandom_range(SIZE_REG_MAX), $urandom_range(SIZE_REG_MAX), $urandom);
      run_random(PHASE_POLLS);
      wait_drained();

      if (tracker.errors == 0 && tracker.due_reports.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/pit_pkg.sv
rtl/pit_if.sv
rtl/pit_csr.sv
rtl/pit_axis.sv
rtl/pit_event.sv
rtl/pointer_input_tracker.sv
rtl/pit_checker.sv
test/pointer_input_tracker_tb.sv
